// ----- rtl/tpw_pkg.sv -----
// Shared constants and types for the three-step phase wrapping pipeline.
package tpw_pkg;

    // Angle accumulator fraction bits (default) and the arctangent table length
    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int TAB_LEN             = 24;

    // Vector datapath: Q24 values, magnitude below 2^34 after CORDIC gain
    localparam int XY_W    = 36;
    localparam int XY_FRAC = 24;

    // round(sqrt(3) * 2^24)
    localparam logic signed [25:0] SQRT3_Q24 = 26'sd29058991;

    // 255 * 255, full-scale modulation squared
    localparam logic [15:0] BG_SCALE = 16'd65025;

    // Configuration register indexes
    localparam int          CFG_IDX_W          = 1;
    localparam int          CFG_DATA_W         = 8;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_LABEL = 1'b1;

    localparam logic [7:0] THRESHOLD_RST        = 8'd16;
    localparam logic [7:0] BACKGROUND_LABEL_RST = 8'd255;

    // Phase code at zero angle
    localparam logic [7:0] PHASE_ZERO = 8'd128;

    // Arctangent of 2^-i in Q24 steps (a turn is 2^32)
    localparam logic [31:0] ATAN_Q24 [0:TAB_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Control that travels with each word down the cell chain
    typedef struct packed {
        logic valid;
        logic hold;   // angle already final, skip rotation
        logic bg;     // background pixel
    } cord_ctl_t;

endpackage

// ----- rtl/tpw_front.sv -----
// Front end: differences, quadrant turn, Q24 vector and background test.
module tpw_front
    import tpw_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [7:0]                            sample_0,
    input  logic [7:0]                            sample_1,
    input  logic [7:0]                            sample_2,
    input  logic [7:0]                            threshold,
    output cord_ctl_t                             ctl,
    output logic signed [XY_W-1:0]                x,
    output logic signed [XY_W-1:0]                y,
    output logic signed [ANGLE_FRAC_BITS+9:0]     z
);

    localparam int ZW = ANGLE_FRAC_BITS + 10;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(64) << ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] HALF    = ZW'(128) << ANGLE_FRAC_BITS;

    // Stage 1: differences and sum
    logic              s1_valid_reg;
    logic signed [8:0] a1_reg;
    logic signed [9:0] b1_reg;
    logic [9:0]        sum1_reg;

    // Stage 2: squares and threshold product
    logic              s2_valid_reg;
    logic signed [8:0] a2_reg;
    logic signed [9:0] b2_reg;
    logic [15:0]       asq_reg;
    logic [17:0]       bsq_reg;
    logic [17:0]       ts_reg;
    logic              sz2_reg;

    // Stage 3: vector and both sides of the modulation test
    logic                   s3_valid_reg;
    logic                   hold3_reg;
    logic                   sz3_reg;
    logic signed [XY_W-1:0] x3_reg;
    logic signed [XY_W-1:0] y3_reg;
    logic signed [ZW-1:0]   z3_reg;
    logic [35:0]            lhs_reg;
    logic [35:0]            rhs_reg;

    logic signed [17:0]     asq_full;
    logic signed [19:0]     bsq_full;
    logic signed [8:0]      am;
    logic signed [XY_W-1:0] prod;
    logic signed [XY_W-1:0] bsh;
    logic signed [XY_W-1:0] nbsh;
    logic                   rot;
    logic                   a_pos;
    logic [18:0]            q;
    logic signed [XY_W-1:0] x3_next;
    logic signed [XY_W-1:0] y3_next;
    logic signed [ZW-1:0]   z3_next;
    logic                   hold3_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    assign asq_full = 18'(a1_reg) * 18'(a1_reg);
    assign bsq_full = 20'(b1_reg) * 20'(b1_reg);

    // Left half plane: turn by a quarter so that x > 0
    always_comb
    begin
        a_pos      = (a2_reg > 9'sd0);
        rot        = b2_reg[9] && (a2_reg != 9'sd0);
        am         = a2_reg[8] ? -a2_reg : a2_reg;
        if (!rot)
            am = a2_reg;
        prod       = XY_W'(am) * XY_W'(SQRT3_Q24);
        bsh        = XY_W'(b2_reg) <<< XY_FRAC;
        nbsh       = -bsh;
        hold3_next = (a2_reg == 9'sd0) || (b2_reg == 10'sd0);
        if (rot)
        begin
            x3_next = prod;
            y3_next = a_pos ? nbsh : bsh;
            z3_next = a_pos ? QUARTER : -QUARTER;
        end
        else
        begin
            x3_next = bsh;
            y3_next = prod;
            z3_next = '0;
        end
        // Axis cases: the angle is exact
        if (a2_reg == 9'sd0)
            z3_next = b2_reg[9] ? HALF : '0;
        else if (b2_reg == 10'sd0)
            z3_next = a_pos ? QUARTER : -QUARTER;
        q = 19'(3) * 19'(asq_reg) + 19'(bsq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= $signed({1'b0, sample_0}) - $signed({1'b0, sample_2});
            b1_reg    <= $signed({1'b0, sample_1, 1'b0}) - $signed({2'b00, sample_0})
                         - $signed({2'b00, sample_2});
            sum1_reg  <= 10'(sample_0) + 10'(sample_1) + 10'(sample_2);

            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            asq_reg   <= asq_full[15:0];
            bsq_reg   <= bsq_full[17:0];
            ts_reg    <= 18'(threshold) * 18'(sum1_reg);
            sz2_reg   <= (sum1_reg == 10'd0);

            x3_reg    <= x3_next;
            y3_reg    <= y3_next;
            z3_reg    <= z3_next;
            hold3_reg <= hold3_next;
            sz3_reg   <= sz2_reg;
            lhs_reg   <= 36'(q) * 36'(BG_SCALE);
            rhs_reg   <= 36'(ts_reg) * 36'(ts_reg);
        end
    end

    assign ctl.valid = s3_valid_reg;
    assign ctl.hold  = hold3_reg;
    assign ctl.bg    = sz3_reg || (lhs_reg < rhs_reg);
    assign x         = x3_reg;
    assign y         = y3_reg;
    assign z         = z3_reg;

endmodule

// ----- rtl/tpw_cordic_cell.sv -----
// One vectoring CORDIC iteration with its stage register.
module tpw_cordic_cell
    import tpw_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int IDX             = 0
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  cord_ctl_t                         in_ctl,
    input  logic signed [XY_W-1:0]            x_in,
    input  logic signed [XY_W-1:0]            y_in,
    input  logic signed [ANGLE_FRAC_BITS+9:0] z_in,
    output cord_ctl_t                         out_ctl,
    output logic signed [XY_W-1:0]            x_out,
    output logic signed [XY_W-1:0]            y_out,
    output logic signed [ANGLE_FRAC_BITS+9:0] z_out
);

    localparam int ZW = ANGLE_FRAC_BITS + 10;
    localparam logic signed [ZW-1:0] STEP =
        ZW'(ATAN_Q24[IDX] >> (TAB_LEN - ANGLE_FRAC_BITS));

    cord_ctl_t              ctl_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [ZW-1:0]   z_reg;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [ZW-1:0]   z_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   y_pos;

    always_comb
    begin
        dx    = y_in >>> IDX;
        dy    = x_in >>> IDX;
        y_pos = !y_in[XY_W-1] && (y_in != '0);
        if (in_ctl.hold)
        begin
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end
        else if (y_pos)
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + STEP;
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;

    // A finished angle passes through untouched
    a_hold_keeps_angle: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_ctl.valid && in_ctl.hold |=> z_reg == $past(z_in))
        else $error("held angle changed in cell");

    // x starts positive after the quarter turn and never shrinks
    a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_ctl.valid && !in_ctl.hold |=> !x_reg[XY_W-1])
        else $error("cordic x went negative");

endmodule

// ----- rtl/tpw_finish.sv -----
// Truncation of the angle to whole steps and mask label selection.
module tpw_finish
    import tpw_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic signed [ANGLE_FRAC_BITS+9:0] z,
    input  logic                              bg,
    input  logic [7:0]                        background_label,
    output logic [7:0]                        wrapped_phase,
    output logic [7:0]                        mask_label
);

    localparam int ZW = ANGLE_FRAC_BITS + 10;

    logic [ZW-1:0] mag;
    logic [7:0]    whole;

    // Truncate toward zero: shift the magnitude, then restore the sign
    always_comb
    begin
        mag   = z[ZW-1] ? unsigned'(-z) : unsigned'(z);
        whole = 8'(mag >> ANGLE_FRAC_BITS);
        if (z[ZW-1])
            whole = -whole;
        wrapped_phase = PHASE_ZERO + whole;
        mask_label    = bg ? background_label : 8'd0;
    end

endmodule

// ----- rtl/three_phase_wrap_pixel.sv -----
// Top level: configuration, front end, CORDIC cell chain and output register.
//
//  channel | signals                                | handshake
//  --------+----------------------------------------+------------------------
//  input   | sample_0, sample_1, sample_2           | in_valid / in_ready
//  output  | wrapped_phase, mask_label              | out_valid / out_ready
//  config  | cfg_index, cfg_data                    | cfg_we, no wait
//
// One word per cycle sustained while out_ready stays high; a word passes through
// three front stages, one cell per CORDIC iteration and the output register.
// The whole chain advances together whenever the output register is empty
// or being taken, so in_ready follows out_ready through that one gate.
// Reset clears the valid bits and loads threshold 16, background label 255.
// A stall on the output freezes every stage in place; nothing is dropped.
module three_phase_wrap_pixel
    import tpw_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            sample_0,
    input  logic [7:0]            sample_1,
    input  logic [7:0]            sample_2,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            wrapped_phase,
    output logic [7:0]            mask_label,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ZW    = ANGLE_FRAC_BITS + 10;
    localparam int CELLS = ANGLE_FRAC_BITS;

    logic [7:0] threshold_reg;
    logic [7:0] background_label_reg;
    logic       out_valid_reg;
    logic [7:0] wrapped_phase_reg;
    logic [7:0] mask_label_reg;
    logic       adv;
    logic [7:0] phase_w;
    logic [7:0] label_w;

    cord_ctl_t              cctl [0:CELLS];
    logic signed [XY_W-1:0] cx   [0:CELLS];
    logic signed [XY_W-1:0] cy   [0:CELLS];
    logic signed [ZW-1:0]   cz   [0:CELLS];

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg        <= THRESHOLD_RST;
            background_label_reg <= BACKGROUND_LABEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:        threshold_reg        <= cfg_data;
                REG_BACKGROUND_LABEL: background_label_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tpw_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .sample_0  (sample_0),
        .sample_1  (sample_1),
        .sample_2  (sample_2),
        .threshold (threshold_reg),
        .ctl       (cctl[0]),
        .x         (cx[0]),
        .y         (cy[0]),
        .z         (cz[0])
    );

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        tpw_cordic_cell #(
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
            .IDX             (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_ctl  (cctl[i]),
            .x_in    (cx[i]),
            .y_in    (cy[i]),
            .z_in    (cz[i]),
            .out_ctl (cctl[i+1]),
            .x_out   (cx[i+1]),
            .y_out   (cy[i+1]),
            .z_out   (cz[i+1])
        );
    end

    tpw_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .z                (cz[CELLS]),
        .bg               (cctl[CELLS].bg),
        .background_label (background_label_reg),
        .wrapped_phase    (phase_w),
        .mask_label       (label_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cctl[CELLS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wrapped_phase_reg <= phase_w;
            mask_label_reg    <= label_w;
        end
    end

    assign out_valid     = out_valid_reg;
    assign wrapped_phase = wrapped_phase_reg;
    assign mask_label    = mask_label_reg;

    // A finished word at the chain end lands in the output register
    a_end_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cctl[CELLS].valid |=> out_valid_reg)
        else $error("word lost between chain and output register");

    // Hold the chain while the output is stalled
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(cctl[CELLS]) && $stable(cz[CELLS]))
        else $error("chain moved during output stall");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the three-step phase wrapping pixel pipeline.
`timescale 1ns / 100ps

module tb;
    import tpw_pkg::*;

    localparam int FRAC    = ANGLE_FRAC_BITS_DEF;
    localparam int LATENCY = FRAC + 4;

    typedef struct packed {
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;
    } pixel_t;

    typedef struct packed {
        logic [7:0] phase;
        logic [7:0] mask;
    } pixel_result_t;

    typedef struct packed {
        pixel_t        px;
        pixel_result_t res;
    } expected_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [7:0]            sample_0  = '0;
    logic [7:0]            sample_1  = '0;
    logic [7:0]            sample_2  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            wrapped_phase;
    logic [7:0]            mask_label;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow copies of the registers, changed only while the pipeline is empty
    logic [7:0] thr_cfg   = THRESHOLD_RST;
    logic [7:0] label_cfg = BACKGROUND_LABEL_RST;

    pixel_t         pixels_to_send[$];
    expected_word_t pending_results[$];
    int             mismatches = 0;
    int             in_gap     = 0;
    int             out_gap    = 0;
    bit             idle_on    = 1'b1;

    three_phase_wrap_pixel #(
        .ANGLE_FRAC_BITS(FRAC)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_0      (sample_0),
        .sample_1      (sample_1),
        .sample_2      (sample_2),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .wrapped_phase (wrapped_phase),
        .mask_label    (mask_label),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // vectoring CORDIC: angle of (x, y) in 1/256 turn steps with FRAC fraction bits
    function automatic longint cordic_steps(longint x_in, longint y_in);
        longint x, y, z, t, dx, dy, step, quarter;
        x = x_in;
        y = y_in;
        z = 0;
        quarter = longint'(64) <<< FRAC;
        if (y == 0)
            return (x < 0) ? 2 * quarter : 0;
        if (x == 0)
            return (y > 0) ? quarter : -quarter;
        // fold the left half plane into the right one
        if (x < 0)
        begin
            t = x;
            if (y > 0)
            begin
                x = y;
                y = -t;
                z = quarter;
            end
            else
            begin
                x = -y;
                y = t;
                z = -quarter;
            end
        end
        for (int i = 0; i < FRAC && i < TAB_LEN; i++)
        begin
            dx   = y >>> i;
            dy   = x >>> i;
            step = longint'(ATAN_Q24[i]) >> (XY_FRAC - FRAC);
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + step;
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - step;
            end
        end
        return z;
    endfunction

    function automatic pixel_result_t phase_and_mask(pixel_t p, logic [7:0] thr,
                                                     logic [7:0] lbl);
        longint s0, s1, s2, a, b, z, whole, total, lhs, rhs;
        pixel_result_t r;
        s0 = p.s0;
        s1 = p.s1;
        s2 = p.s2;
        a  = s0 - s2;
        b  = 2 * s1 - s0 - s2;
        z  = cordic_steps(b <<< XY_FRAC, a * longint'(SQRT3_Q24));
        // truncate toward zero to whole steps
        whole = (z >= 0) ? (z >>> FRAC) : -((-z) >>> FRAC);
        r.phase = 8'(whole + longint'(PHASE_ZERO));
        total = s0 + s1 + s2;
        lhs   = longint'(BG_SCALE) * (3 * a * a + b * b);
        rhs   = longint'(thr) * longint'(thr) * total * total;
        r.mask = (total == 0 || lhs < rhs) ? lbl : 8'd0;
        return r;
    endfunction

    function automatic logic [7:0] near_level(int base, int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        int kind, base, spread;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            p.s0 = 8'($urandom);
            p.s1 = 8'($urandom);
            p.s2 = 8'($urandom);
        end
        else if (kind < 8)
        begin
            // weak fringe: samples close together, near the background test edge
            base   = $urandom_range(0, 255);
            spread = $urandom_range(0, $urandom_range(0, 1) ? 8 : 60);
            p.s0 = near_level(base, spread);
            p.s1 = near_level(base, spread);
            p.s2 = near_level(base, spread);
        end
        else if (kind == 8)
        begin
            p.s0 = 8'($urandom);
            p.s1 = 8'($urandom);
            if ($urandom_range(0, 1))
                p.s2 = p.s0;
            else
            begin
                // same parity so the midpoint is exact and b is zero
                p.s2 = {7'($urandom), p.s0[0]};
                p.s1 = 8'((9'(p.s0) + 9'(p.s2)) >> 1);
            end
        end
        else
        begin
            p.s0 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.s1 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            p.s2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    task automatic queue_pixel(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [7:0] s2);
        pixel_t p;
        p.s0 = s0;
        p.s1 = s1;
        p.s2 = s2;
        pixels_to_send.push_back(p);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pixels_to_send.push_back(random_pixel());
    endtask

    task automatic report_mismatch(input string what, input int got, input int want,
                                   input pixel_t px);
        if (mismatches < 100)
            $display("tb: mismatch %s got %0d expected %0d for pixel %0d %0d %0d at %0t",
                     what, got, want, px.s0, px.s1, px.s2, $time);
        mismatches++;
    endtask

    // all queued words sent and every result back
    task automatic wait_drained();
        @(negedge clk);
        while (pixels_to_send.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_THRESHOLD)
            thr_cfg = val;
        else
            label_cfg = val;
    endtask

    // driver: pop pending pixels, hold each word until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_results.push_back('{px: '{s0: sample_0, s1: sample_1, s2: sample_2},
                    res: phase_and_mask('{s0: sample_0, s1: sample_1, s2: sample_2},
                                        thr_cfg, label_cfg)});
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (pixels_to_send.size() > 0)
                begin
                    {sample_0, sample_1, sample_2} <= pixels_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        in_gap <= $urandom_range(1, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: stall at random, check each taken word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        expected_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected word, phase", wrapped_phase, -1, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (wrapped_phase !== want.res.phase)
                        report_mismatch("wrapped_phase", wrapped_phase, want.res.phase,
                                        want.px);
                    if (mask_label !== want.res.mask)
                        report_mismatch("mask_label", mask_label, want.res.mask, want.px);
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    out_gap <= $urandom_range(1, 13);
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero sum, flat pixels, both axes, every quadrant,
        // near the minus half turn, weak fringes at the background edge
        idle_on = 1'b1;
        queue_pixel(8'd0,   8'd0,   8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_pixel(8'd128, 8'd128, 8'd128);
        queue_pixel(8'd0,   8'd255, 8'd0);
        queue_pixel(8'd255, 8'd0,   8'd255);
        queue_pixel(8'd200, 8'd100, 8'd0);
        queue_pixel(8'd0,   8'd100, 8'd200);
        queue_pixel(8'd255, 8'd0,   8'd0);
        queue_pixel(8'd0,   8'd0,   8'd255);
        queue_pixel(8'd255, 8'd255, 8'd0);
        queue_pixel(8'd0,   8'd255, 8'd255);
        queue_pixel(8'd254, 8'd0,   8'd255);
        queue_pixel(8'd100, 8'd0,   8'd101);
        queue_pixel(8'd0,   8'd0,   8'd1);
        queue_pixel(8'd1,   8'd0,   8'd0);
        queue_pixel(8'd100, 8'd101, 8'd100);
        queue_pixel(8'd100, 8'd104, 8'd100);
        queue_pixel(8'd100, 8'd110, 8'd100);
        queue_pixel(8'd120, 8'd100, 8'd100);
        queue_pixel(8'd255, 8'd128, 8'd0);
        queue_pixel(8'd85,  8'd170, 8'd255);
        queue_pixel(8'd170, 8'd85,  8'd0);
        queue_random(80);
        wait_drained();

        // only a zero sum is background
        write_reg(REG_THRESHOLD, 8'd0);
        write_reg(REG_BACKGROUND_LABEL, 8'hA5);
        @(negedge clk);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd255, 8'd255);
        queue_random(80);
        wait_drained();

        // nearly everything is background
        write_reg(REG_THRESHOLD, 8'd255);
        write_reg(REG_BACKGROUND_LABEL, 8'd1);
        @(negedge clk);
        queue_pixel(8'd0, 8'd0, 8'd0);
        queue_pixel(8'd255, 8'd0, 8'd0);
        queue_random(80);
        wait_drained();

        write_reg(REG_THRESHOLD, 8'($urandom_range(1, 254)));
        write_reg(REG_BACKGROUND_LABEL, 8'd0);
        @(negedge clk);
        queue_random(80);
        wait_drained();

        // last stretch: random settings, no idling on either side
        write_reg(REG_BACKGROUND_LABEL, 8'd255);
        write_reg(REG_THRESHOLD, 8'($urandom_range(0, 255)));
        write_reg(REG_BACKGROUND_LABEL, 8'($urandom_range(0, 255)));
        @(negedge clk);
        idle_on = 1'b0;
        queue_random(100);
        wait_drained();

        repeat (LATENCY + 8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- three_phase_wrap_pixel.f -----
rtl/tpw_pkg.sv
rtl/tpw_front.sv
rtl/tpw_cordic_cell.sv
rtl/tpw_finish.sv
rtl/three_phase_wrap_pixel.sv
verif/tb.sv
